@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define SHABH_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SHABH_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/shabh_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Transaction types, controller/datapath interface types and SHA-256 constants.
// ----------------------------------------------------------------------------
`default_nettype none

package shabh_pkg;

    // One input transaction: a message byte and/or the end-of-message mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } msg_item_t;

    // One output transaction: a digest word and its position.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } digest_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_byte;
        logic       pad_byte;
        logic       pad_mark;
        logic       pad_len_ok;
        logic       latch_len;
        logic       start_blk;
        logic       round_en;
        logic [5:0] round_idx;
        logic       update;
        logic       add_bits;
        logic       emit;
        logic [2:0] word_idx;
        logic       restart;
    } shabh_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] fill;
        logic       out_free;
    } shabh_status_t;

    localparam logic [5:0]  LastFill     = 6'd63;
    localparam logic [5:0]  LastRound    = 6'd63;
    localparam logic [5:0]  LengthPos    = 6'd56;
    localparam logic [2:0]  LastWord     = 3'd7;
    localparam logic [7:0]  PadMark      = 8'h80;
    localparam logic [63:0] BlockBits    = 64'd512;

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

endpackage

`default_nettype wire

@@ hdl/shabh_ctrl.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hasher controller
// Sequences byte loading, padding, the 64 compression rounds and digest output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module shabh_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    msg_valid,
    output logic                         msg_stall,
    input  wire shabh_pkg::msg_item_t    msg,
    input  wire shabh_pkg::shabh_status_t sts,
    output shabh_pkg::shabh_cmd_t        cmd
);
    import shabh_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PSTART = 7'b0000010,
        S_PAD    = 7'b0000100,
        S_LOAD   = 7'b0001000,
        S_ROUND  = 7'b0010000,
        S_UPDATE = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] round_reg, round_next;
    logic [2:0] word_reg, word_next;
    logic       pend_end_reg, pend_end_next;
    logic       pad_phase_reg, pad_phase_next;
    logic       final_reg, final_next;
    logic       first_reg, first_next;
    logic       accept;

    assign msg_stall = (state_reg != S_IDLE);
    assign accept    = msg_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        word_next      = word_reg;
        pend_end_next  = pend_end_reg;
        pad_phase_next = pad_phase_reg;
        final_next     = final_reg;
        first_next     = first_reg;
        cmd            = '0;
        cmd.round_idx  = round_reg;
        cmd.word_idx   = word_reg;
        cmd.pad_mark   = first_reg;
        cmd.pad_len_ok = final_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_byte = msg.byte_valid;
                    pend_end_next = msg.end_of_message;
                    if (msg.byte_valid && (sts.fill == LastFill))
                    begin
                        state_next = S_LOAD;
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next = S_PSTART;
                    end
                end
            end
            S_PSTART:
            begin
                // The length fits in this block only if the mark lands before it.
                cmd.latch_len  = 1'b1;
                pad_phase_next = 1'b1;
                final_next     = (sts.fill < LengthPos);
                first_next     = 1'b1;
                state_next     = S_PAD;
            end
            S_PAD:
            begin
                cmd.pad_byte = 1'b1;
                first_next   = 1'b0;
                if (sts.fill == LastFill)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.start_blk = 1'b1;
                round_next    = '0;
                state_next    = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == LastRound)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update   = 1'b1;
                cmd.add_bits = !pad_phase_reg;
                if (!pend_end_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (!pad_phase_reg)
                begin
                    state_next = S_PSTART;
                end
                else if (final_reg)
                begin
                    word_next  = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    // The mark overflowed into an extra block; it carries the length.
                    final_next = 1'b1;
                    state_next = S_PAD;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit  = 1'b1;
                    word_next = word_reg + 3'd1;
                    if (word_reg == LastWord)
                    begin
                        cmd.restart    = 1'b1;
                        pend_end_next  = 1'b0;
                        pad_phase_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            round_reg     <= '0;
            word_reg      <= '0;
            pend_end_reg  <= 1'b0;
            pad_phase_reg <= 1'b0;
            final_reg     <= 1'b0;
            first_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            word_reg      <= word_next;
            pend_end_reg  <= pend_end_next;
            pad_phase_reg <= pad_phase_next;
            final_reg     <= final_next;
            first_reg     <= first_next;
        end
    end

    `SHABH_ASSERT(a_emit_needs_room, clk, rst_n, cmd.emit |-> sts.out_free, "digest word issued into a busy output register")
    `SHABH_ASSERT(a_round_end, clk, rst_n, (state_reg == S_ROUND && round_reg == LastRound) |=> (state_reg == S_UPDATE), "compression did not end after the last round")
    `SHABH_ASSERT(a_last_word_idle, clk, rst_n, (cmd.emit && word_reg == LastWord) |=> (state_reg == S_IDLE && !pend_end_reg), "controller did not return to idle after the last digest word")

endmodule

`default_nettype wire

@@ hdl/shabh_datapath.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hasher datapath
// Block buffer, message schedule window, round unit, chaining value and output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module shabh_datapath (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire shabh_pkg::msg_item_t     msg,
    input  wire shabh_pkg::shabh_cmd_t    cmd,
    output shabh_pkg::shabh_status_t      sts,
    output logic                          dig_valid,
    input  wire logic                     dig_stall,
    output shabh_pkg::digest_item_t       dig
);
    import shabh_pkg::*;

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    logic [31:0]  buf_reg   [16];
    logic [31:0]  win_reg   [16];
    logic [31:0]  vars_reg  [8];
    logic [31:0]  chain_reg [8];
    logic [5:0]   fill_reg;
    logic [63:0]  bits_reg;
    logic [63:0]  len_reg;
    logic         dig_valid_reg;
    digest_item_t dig_reg;

    logic [7:0]   len_byte;
    logic [7:0]   wr_byte;
    logic [31:0]  wr_word;
    logic         wr_en;
    logic [31:0]  w_new;
    logic [31:0]  t1;
    logic [31:0]  t2;
    logic [31:0]  ch;
    logic [31:0]  maj;
    logic         out_free;

    assign out_free     = !dig_valid_reg || !dig_stall;
    assign sts.fill     = fill_reg;
    assign sts.out_free = out_free;
    assign dig_valid    = dig_valid_reg;
    assign dig          = dig_reg;

    // Length bytes go out most significant first at positions 56 to 63.
    always_comb
    begin
        case (fill_reg[2:0])
            3'd0:    len_byte = len_reg[63:56];
            3'd1:    len_byte = len_reg[55:48];
            3'd2:    len_byte = len_reg[47:40];
            3'd3:    len_byte = len_reg[39:32];
            3'd4:    len_byte = len_reg[31:24];
            3'd5:    len_byte = len_reg[23:16];
            3'd6:    len_byte = len_reg[15:8];
            default: len_byte = len_reg[7:0];
        endcase
    end

    always_comb
    begin
        wr_en   = cmd.load_byte || cmd.pad_byte;
        wr_byte = 8'd0;
        if (cmd.load_byte)
        begin
            wr_byte = msg.data_byte;
        end
        else if (cmd.pad_mark)
        begin
            wr_byte = PadMark;
        end
        else if (cmd.pad_len_ok && (fill_reg >= LengthPos))
        begin
            wr_byte = len_byte;
        end
        wr_word = buf_reg[fill_reg[5:2]];
        case (fill_reg[1:0])
            2'd0:    wr_word[31:24] = wr_byte;
            2'd1:    wr_word[23:16] = wr_byte;
            2'd2:    wr_word[15:8]  = wr_byte;
            default: wr_word[7:0]   = wr_byte;
        endcase
    end

    always_comb
    begin
        w_new = small_sigma1(win_reg[14]) + win_reg[9] + small_sigma0(win_reg[1]) + win_reg[0];
        ch    = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        maj   = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
              ^ (vars_reg[1] & vars_reg[2]);
        t1    = vars_reg[7] + big_sigma1(vars_reg[4]) + ch + RoundK[cmd.round_idx] + win_reg[0];
        t2    = big_sigma0(vars_reg[0]) + maj;
    end

    // Payload storage: buffer, schedule window and working variables.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_reg[fill_reg[5:2]] <= wr_word;
        end
        if (cmd.start_blk)
        begin
            for (int i = 0; i < 16; i++)
            begin
                win_reg[i] <= buf_reg[i];
            end
            for (int i = 0; i < 8; i++)
            begin
                vars_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15]  <= w_new;
            vars_reg[7]  <= vars_reg[6];
            vars_reg[6]  <= vars_reg[5];
            vars_reg[5]  <= vars_reg[4];
            vars_reg[4]  <= vars_reg[3] + t1;
            vars_reg[3]  <= vars_reg[2];
            vars_reg[2]  <= vars_reg[1];
            vars_reg[1]  <= vars_reg[0];
            vars_reg[0]  <= t1 + t2;
        end
        if (cmd.latch_len)
        begin
            len_reg <= bits_reg + {55'd0, fill_reg, 3'b000};
        end
        if (cmd.emit)
        begin
            dig_reg.digest_word <= chain_reg[cmd.word_idx];
            dig_reg.word_index  <= cmd.word_idx;
            dig_reg.digest_last <= (cmd.word_idx == LastWord);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            bits_reg      <= '0;
            dig_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= InitHash[i];
            end
        end
        else
        begin
            if (wr_en)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.update)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + vars_reg[i];
                end
                if (cmd.add_bits)
                begin
                    bits_reg <= bits_reg + BlockBits;
                end
            end
            else if (cmd.restart)
            begin
                fill_reg <= '0;
                bits_reg <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= InitHash[i];
                end
            end
            if (cmd.emit)
            begin
                dig_valid_reg <= 1'b1;
            end
            else if (!dig_stall)
            begin
                dig_valid_reg <= 1'b0;
            end
        end
    end

    `SHABH_ASSERT(a_update_at_block_start, clk, rst_n, cmd.update |-> (fill_reg == 6'd0), "chaining update while the block buffer is partly filled")
    `SHABH_ASSERT(a_restart_clears, clk, rst_n, cmd.restart |=> (fill_reg == 6'd0 && bits_reg == 64'd0 && chain_reg[0] == InitHash[0]), "hash state not restored after the digest")
    `SHABH_ASSERT(a_dig_hold, clk, rst_n,
        (dig_valid_reg && dig_stall) |=> (dig_valid_reg && $stable(dig_reg)),
        "stalled digest transaction changed")

endmodule

`default_nettype wire

@@ hdl/sha256_byte_stream_hasher_unit.sv @@
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte stream with SHA-256 and returns the digest as eight words.
// ----------------------------------------------------------------------------
// Usage:
// The msg channel carries one transaction per message byte (byte_valid set),
// optionally with end_of_message set on the final one; an end-only transaction
// (byte_valid clear) closes the message, and on an empty one hashes the empty message.
// A transaction with neither flag set is accepted and has no effect.
// A byte that does not complete a 64-byte block is taken without a stall. The
// byte that completes a block starts the compression, which holds msg_stall
// high through the load, 64 rounds on one shared round unit and the chain
// update, so no further byte is taken until that block is compressed.
// After end_of_message the block writes padding one byte per cycle up to the
// block end, compresses, and may need a second padded block when fewer than
// nine bytes of room remained; the first digest word appears on the dig
// channel after the last padded block is compressed.
// The eight digest transactions leave through one output register, word 0
// first; digest_last marks word 7. A stall on dig holds the current word and
// pauses the emission, while the last word may still wait in the output
// register as the next message begins. Reset clears the message state and
// loads the SHA-256 initial hash value; no digest is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_byte_stream_hasher_unit (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   msg_valid,
    output logic                        msg_stall,
    input  wire shabh_pkg::msg_item_t   msg,
    output logic                        dig_valid,
    input  wire logic                   dig_stall,
    output shabh_pkg::digest_item_t     dig
);
    import shabh_pkg::*;

    shabh_cmd_t    cmd;
    shabh_status_t sts;

    // The controller owns the sequencing; the datapath owns all hash state.
    shabh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .sts       (sts),
        .cmd       (cmd)
    );

    shabh_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .cmd       (cmd),
        .sts       (sts),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig       (dig)
    );

endmodule

`default_nettype wire
